FILE: rtl/core/array_table_engine_defines.svh
// assertion macros for the array table engine
`ifndef ARRAY_TABLE_ENGINE_DEFINES_SVH
`define ARRAY_TABLE_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
`define ATE_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
`define ATE_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define ATE_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define ATE_ASSERT_NXT(lbl, ck, rn, ante, cons, msg)
`endif

`endif

FILE: rtl/core/ate_pkg.sv
`timescale 1ns / 1ps

package ate_pkg;

	localparam int OP_W   = 3;
	localparam int POS_W  = 7;
	localparam int VAL_W  = 32;
	localparam int STAT_W = 3;
	localparam int CNT_W  = 7;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT  = 3'd0,
		OP_DELETE  = 3'd1,
		OP_SORT    = 3'd2,
		OP_SEARCH  = 3'd3,
		OP_DISPLAY = 3'd4
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 3'd0,
		STAT_FULL      = 3'd1,
		STAT_BAD_POS   = 3'd2,
		STAT_EMPTY     = 3'd3,
		STAT_NOT_FOUND = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_MV,
		S_INS_PUT,
		S_DEL_RD,
		S_DEL_MV,
		S_SRT_RDI,
		S_SRT_LDI,
		S_SRT_RDJ,
		S_SRT_CMP,
		S_SRT_WRI,
		S_SCN_RD,
		S_SCN_CHK,
		S_SCN_END,
		S_RESP
	} state_t;

	typedef struct packed {
		status_t            status;
		logic [POS_W-1:0]   position;
		logic [VAL_W-1:0]   value;
		logic [CNT_W-1:0]   count;
		logic               last;
	} out_word_t;

endpackage

FILE: rtl/core/ate_ram.sv
`timescale 1ns / 1ps

module ate_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/core/array_table_engine.sv
`timescale 1ns / 1ps
// channel   dir  tdata                                   tuser       tlast
// s_axis    in   [6:0] position, [38:7] value            [2:0] op    -
// m_axis    out  [6:0] position_res, [38:7] value_res,   [2:0] status last
//                [45:39] count
//
// one op at a time; s_axis_tready is high only while the sequencer is idle
// the table sits in one ram with a single registered read port
// arst_n clears the count and control; the ram is not cleared
// a full output register stalls the sequencer until m_axis_tready
`include "array_table_engine_defines.svh"

module array_table_engine
	import ate_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // position, value
	input  logic [2:0]  s_axis_tuser,  // op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // position_res, value_res, count
	output logic [2:0]  m_axis_tuser,  // status
	output logic        m_axis_tlast
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;

	state_t           state_q, state_d;
	op_t              in_op, op_q;
	logic [POS_W-1:0] in_position;
	logic [VAL_W-1:0] in_value;
	logic             s_acc;

	logic [CW-1:0]    cnt_q;
	logic [AW-1:0]    idx_q, jdx_q, pos_q, pend_pos_q;
	logic [VAL_W-1:0] val_q, cur_q;
	status_t          stat_q;
	logic             pend_q;

	logic [PW-1:0]    pos_ext, cnt_ext, idx_p1, pend_p1, pos_m1_ext;
	logic [AW-1:0]    pos_m1;
	logic             ins_full, ins_bad, ins_shift;
	logic             del_empty, del_bad, del_shift;
	status_t          start_stat;
	logic [CNT_W-1:0] cnt7;

	logic             slot_free, scan_last, j_end, pair_end, ins_at_pos;
	logic             match, swap, scan_go;

	logic             ram_we, ram_re;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	logic [VAL_W-1:0] ram_wdata, ram_rdata;

	logic             out_ld;
	out_word_t        out_d, out_q;
	logic             m_valid_q;

	assign in_op         = op_t'(s_axis_tuser[2:0]);
	assign in_position   = s_axis_tdata[6:0];
	assign in_value      = s_axis_tdata[38:7];
	assign s_axis_tready = (state_q == S_IDLE);
	assign s_acc         = s_axis_tvalid && s_axis_tready;

	assign pos_ext    = PW'(in_position);
	assign cnt_ext    = PW'(cnt_q);
	assign pos_m1_ext = pos_ext - PW'(1);
	assign pos_m1     = pos_m1_ext[AW-1:0];
	assign idx_p1     = PW'(idx_q) + PW'(1);
	assign pend_p1    = PW'(pend_pos_q) + PW'(1);
	assign cnt7       = cnt_ext[CNT_W-1:0];

	assign slot_free  = !m_valid_q || m_axis_tready;
	assign scan_last  = (CW'(idx_q) + CW'(1)) == cnt_q;
	assign j_end      = (CW'(jdx_q) + CW'(1)) == cnt_q;
	assign pair_end   = (CW'(idx_q) + CW'(2)) == cnt_q;
	assign ins_at_pos = (idx_q - AW'(1)) == pos_q;
	assign match      = (ram_rdata == val_q);
	assign swap       = $signed(cur_q) > $signed(ram_rdata);
	assign scan_go    = (op_q == OP_DISPLAY) ? slot_free : !(match && pend_q && !slot_free);

	// op decode at accept
	always_comb begin
		ins_full   = (cnt_q == CW'(DEPTH));
		ins_bad    = (pos_ext == '0) || (pos_ext > cnt_ext + PW'(1));
		ins_shift  = (pos_ext <= cnt_ext);
		del_empty  = (cnt_q == '0);
		del_bad    = (pos_ext == '0) || (pos_ext > cnt_ext);
		del_shift  = (pos_ext < cnt_ext);
		start_stat = STAT_OK;
		unique case (in_op)
			OP_INSERT: begin
				if (ins_full) begin
					start_stat = STAT_FULL;
				end else if (ins_bad) begin
					start_stat = STAT_BAD_POS;
				end
			end
			OP_DELETE: begin
				if (del_empty) begin
					start_stat = STAT_EMPTY;
				end else if (del_bad) begin
					start_stat = STAT_BAD_POS;
				end
			end
			OP_SEARCH, OP_DISPLAY: begin
				if (del_empty) begin
					start_stat = STAT_EMPTY;
				end
			end
			default: start_stat = STAT_OK;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_acc) begin
					case (in_op)
						OP_INSERT: begin
							if (ins_full || ins_bad) begin
								state_d = S_RESP;
							end else if (ins_shift) begin
								state_d = S_INS_RD;
							end else begin
								state_d = S_INS_PUT;
							end
						end
						OP_DELETE: begin
							if (!del_empty && !del_bad && del_shift) begin
								state_d = S_DEL_RD;
							end else begin
								state_d = S_RESP;
							end
						end
						OP_SORT: begin
							if (cnt_q > CW'(1)) begin
								state_d = S_SRT_RDI;
							end else begin
								state_d = S_RESP;
							end
						end
						OP_SEARCH, OP_DISPLAY: begin
							state_d = del_empty ? S_RESP : S_SCN_RD;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_INS_RD:  state_d = S_INS_MV;
			S_INS_MV:  state_d = ins_at_pos ? S_INS_PUT : S_INS_RD;
			S_INS_PUT: state_d = S_RESP;
			S_DEL_RD:  state_d = S_DEL_MV;
			S_DEL_MV:  state_d = pair_end ? S_RESP : S_DEL_RD;
			S_SRT_RDI: state_d = S_SRT_LDI;
			S_SRT_LDI: state_d = S_SRT_RDJ;
			S_SRT_RDJ: state_d = S_SRT_CMP;
			S_SRT_CMP: state_d = j_end ? S_SRT_WRI : S_SRT_RDJ;
			S_SRT_WRI: state_d = pair_end ? S_RESP : S_SRT_RDI;
			S_SCN_RD:  state_d = S_SCN_CHK;
			S_SCN_CHK: begin
				if (scan_go) begin
					if (!scan_last) begin
						state_d = S_SCN_RD;
					end else if (op_q == OP_DISPLAY) begin
						state_d = S_IDLE;
					end else begin
						state_d = S_SCN_END;
					end
				end
			end
			S_SCN_END, S_RESP: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// ram and output word controls
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = idx_q;
		out_ld    = 1'b0;
		out_d     = '{STAT_OK, '0, '0, cnt7, 1'b1};
		unique case (state_q)
			S_INS_RD: begin
				ram_re    = 1'b1;
				ram_raddr = idx_q - AW'(1);
			end
			S_INS_MV, S_DEL_MV: begin
				ram_we = 1'b1;
			end
			S_INS_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q;
				ram_wdata = val_q;
			end
			S_DEL_RD: begin
				ram_re    = 1'b1;
				ram_raddr = idx_q + AW'(1);
			end
			S_SRT_RDI, S_SCN_RD: begin
				ram_re = 1'b1;
			end
			S_SRT_RDJ: begin
				ram_re    = 1'b1;
				ram_raddr = jdx_q;
			end
			S_SRT_CMP: begin
				ram_we    = swap;
				ram_waddr = jdx_q;
				ram_wdata = cur_q;
			end
			S_SRT_WRI: begin
				ram_we    = 1'b1;
				ram_wdata = cur_q;
			end
			S_SCN_CHK: begin
				if (op_q == OP_DISPLAY) begin
					out_ld = slot_free;
					out_d  = '{STAT_OK, idx_p1[POS_W-1:0], ram_rdata, cnt7, scan_last};
				end else begin
					out_ld = match && pend_q && slot_free;
					out_d  = '{STAT_OK, pend_p1[POS_W-1:0], val_q, cnt7, 1'b0};
				end
			end
			S_SCN_END: begin
				out_ld = slot_free;
				if (pend_q) begin
					out_d = '{STAT_OK, pend_p1[POS_W-1:0], val_q, cnt7, 1'b1};
				end else begin
					out_d = '{STAT_NOT_FOUND, '0, '0, cnt7, 1'b1};
				end
			end
			S_RESP: begin
				out_ld = slot_free;
				out_d  = '{stat_q, '0, '0, cnt7, 1'b1};
			end
			default: out_ld = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// table count and search bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			pend_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						pend_q <= 1'b0;
						if (in_op == OP_DELETE && !del_empty && !del_bad && !del_shift) begin
							cnt_q <= cnt_q - CW'(1);
						end
					end
				end
				S_INS_PUT: cnt_q <= cnt_q + CW'(1);
				S_DEL_MV: begin
					if (pair_end) begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				S_SCN_CHK: begin
					if (op_q == OP_SEARCH && scan_go && match) begin
						pend_q <= 1'b1;
					end
				end
				default: pend_q <= pend_q;
			endcase
		end
	end

	// walk indices and operands
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_acc) begin
					op_q   <= in_op;
					val_q  <= in_value;
					pos_q  <= pos_m1;
					stat_q <= start_stat;
					if (in_op == OP_INSERT) begin
						idx_q <= cnt_q[AW-1:0];
					end else if (in_op == OP_DELETE) begin
						idx_q <= pos_m1;
					end else begin
						idx_q <= '0;
					end
				end
			end
			S_INS_MV: begin
				if (!ins_at_pos) begin
					idx_q <= idx_q - AW'(1);
				end
			end
			S_DEL_MV, S_SRT_WRI: begin
				if (!pair_end) begin
					idx_q <= idx_q + AW'(1);
				end
			end
			S_SRT_LDI: begin
				cur_q <= ram_rdata;
				jdx_q <= idx_q + AW'(1);
			end
			S_SRT_CMP: begin
				if (swap) begin
					cur_q <= ram_rdata;
				end
				if (!j_end) begin
					jdx_q <= jdx_q + AW'(1);
				end
			end
			S_SCN_CHK: begin
				if (scan_go) begin
					if (match) begin
						pend_pos_q <= idx_q;
					end
					if (!scan_last) begin
						idx_q <= idx_q + AW'(1);
					end
				end
			end
			default: idx_q <= idx_q;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_ld) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			out_q <= out_d;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tdata  = {2'b00, out_q.count, out_q.value, out_q.position};
	assign m_axis_tlast  = out_q.last;

	ate_ram #(
		.WIDTH(VAL_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	`ATE_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= CW'(DEPTH), "count beyond depth")
	`ATE_ASSERT_IMP(a_scan_idx, clk, arst_n, state_q == S_SCN_CHK, CW'(idx_q) < cnt_q,
		"scan past count")
	`ATE_ASSERT_IMP(a_nonlast_word, clk, arst_n, m_axis_tvalid && !m_axis_tlast,
		(m_axis_tuser == STAT_OK) && (m_axis_tdata[6:0] != 7'd0), "bad non-last word")
	`ATE_ASSERT_NXT(a_ins_count, clk, arst_n, state_q == S_INS_PUT,
		(cnt_q - $past(cnt_q)) == CW'(1), "insert count step")

endmodule

FILE: sim/tb_array_table_engine.sv
`timescale 1ns / 1ps

module tb_array_table_engine;
	import ate_pkg::*;

	localparam int TABLE_DEPTH = 64;
	localparam int N_DIRECTED  = 25;
	localparam int N_RANDOM    = 270;
	localparam int IDLE_PCT    = 18;
	localparam int DRAIN_CYCLES = 100;

	localparam logic [OP_W-1:0] OP_RSV_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_RSV_MID   = 3'd6;
	localparam logic [OP_W-1:0] OP_RSV_LAST  = 3'd7;

	localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
	localparam logic [VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;
	localparam logic [VAL_W-1:0] VAL_NEG1 = 32'hffff_ffff;

	typedef struct {
		logic [OP_W-1:0]  op;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] val;
		bit               lit;
		status_t          lit_status;
		logic [CNT_W-1:0] lit_count;
	} table_cmd_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic [2:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;

	bit steady = 1'b0;
	bit failed = 1'b0;

	logic [VAL_W-1:0] table_vals [TABLE_DEPTH];
	int               n_entries = 0;
	out_word_t        expected_words [$];

	table_cmd_t directed_cmds [N_DIRECTED] = '{
		'{OP_SEARCH,  7'd0,   32'd5,    1'b1, STAT_EMPTY,     7'd0},
		'{OP_DISPLAY, 7'd0,   32'd0,    1'b1, STAT_EMPTY,     7'd0},
		'{OP_DELETE,  7'd1,   32'd0,    1'b1, STAT_EMPTY,     7'd0},
		'{OP_SORT,    7'd0,   32'd0,    1'b1, STAT_OK,        7'd0},
		'{OP_INSERT,  7'd0,   32'd9,    1'b1, STAT_BAD_POS,   7'd0},
		'{OP_INSERT,  7'd2,   32'd9,    1'b1, STAT_BAD_POS,   7'd0},
		'{OP_INSERT,  7'd1,   VAL_MAX,  1'b1, STAT_OK,        7'd1},
		'{OP_INSERT,  7'd2,   VAL_MIN,  1'b1, STAT_OK,        7'd2},
		'{OP_INSERT,  7'd1,   32'd0,    1'b1, STAT_OK,        7'd3},
		'{OP_INSERT,  7'd127, VAL_NEG1, 1'b1, STAT_BAD_POS,   7'd3},
		'{OP_INSERT,  7'd4,   VAL_NEG1, 1'b1, STAT_OK,        7'd4},
		'{OP_INSERT,  7'd2,   VAL_MAX,  1'b1, STAT_OK,        7'd5},
		'{OP_DISPLAY, 7'd0,   32'd0,    1'b0, STAT_OK,        7'd0},
		'{OP_SEARCH,  7'd0,   VAL_MAX,  1'b0, STAT_OK,        7'd0},
		'{OP_SEARCH,  7'd0,   32'd12345, 1'b1, STAT_NOT_FOUND, 7'd5},
		'{OP_RSV_FIRST, 7'd1, 32'd1,    1'b0, STAT_OK,        7'd0},
		'{OP_RSV_LAST, 7'd3,  VAL_NEG1, 1'b0, STAT_OK,        7'd0},
		'{OP_SORT,    7'd0,   32'd0,    1'b1, STAT_OK,        7'd5},
		'{OP_DISPLAY, 7'd0,   32'd0,    1'b0, STAT_OK,        7'd0},
		'{OP_DELETE,  7'd0,   32'd0,    1'b1, STAT_BAD_POS,   7'd5},
		'{OP_DELETE,  7'd6,   32'd0,    1'b1, STAT_BAD_POS,   7'd5},
		'{OP_DELETE,  7'd5,   32'd0,    1'b1, STAT_OK,        7'd4},
		'{OP_DELETE,  7'd1,   32'd0,    1'b1, STAT_OK,        7'd3},
		'{OP_RSV_MID, 7'd64,  VAL_MIN,  1'b0, STAT_OK,        7'd0},
		'{OP_SEARCH,  7'd0,   32'd0,    1'b0, STAT_OK,        7'd0}
	};

	array_table_engine #(.DEPTH(TABLE_DEPTH)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	function automatic void push_word(status_t st, int pos, logic [VAL_W-1:0] val, bit last);
		out_word_t w;
		w.status   = st;
		w.position = pos[POS_W-1:0];
		w.value    = val;
		w.count    = n_entries[CNT_W-1:0];
		w.last     = last;
		expected_words.push_back(w);
	endfunction

	function automatic void table_apply(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
			logic [VAL_W-1:0] val);
		int k;
		int m;
		int hits;
		logic [VAL_W-1:0] t;
		out_word_t w;
		hits = 0;
		case (op)
			OP_INSERT: begin
				if (n_entries >= TABLE_DEPTH) begin
					push_word(STAT_FULL, 0, '0, 1'b1);
				end else if (pos < 1 || pos > n_entries + 1) begin
					push_word(STAT_BAD_POS, 0, '0, 1'b1);
				end else begin
					for (k = n_entries; k > pos - 1; k--)
						table_vals[k] = table_vals[k-1];
					table_vals[pos-1] = val;
					n_entries++;
					push_word(STAT_OK, 0, '0, 1'b1);
				end
			end
			OP_DELETE: begin
				if (n_entries == 0) begin
					push_word(STAT_EMPTY, 0, '0, 1'b1);
				end else if (pos < 1 || pos > n_entries) begin
					push_word(STAT_BAD_POS, 0, '0, 1'b1);
				end else begin
					for (k = pos - 1; k + 1 < n_entries; k++)
						table_vals[k] = table_vals[k+1];
					n_entries--;
					push_word(STAT_OK, 0, '0, 1'b1);
				end
			end
			OP_SORT: begin
				for (k = 0; k < n_entries; k++)
					for (m = k + 1; m < n_entries; m++)
						if ($signed(table_vals[k]) > $signed(table_vals[m])) begin
							t = table_vals[k];
							table_vals[k] = table_vals[m];
							table_vals[m] = t;
						end
				push_word(STAT_OK, 0, '0, 1'b1);
			end
			OP_SEARCH: begin
				if (n_entries == 0) begin
					push_word(STAT_EMPTY, 0, '0, 1'b1);
				end else begin
					for (k = 0; k < n_entries; k++)
						if (table_vals[k] == val) begin
							push_word(STAT_OK, k + 1, val, 1'b0);
							hits++;
						end
					if (hits == 0) begin
						push_word(STAT_NOT_FOUND, 0, '0, 1'b1);
					end else begin
						w = expected_words.pop_back();
						w.last = 1'b1;
						expected_words.push_back(w);
					end
				end
			end
			OP_DISPLAY: begin
				if (n_entries == 0) begin
					push_word(STAT_EMPTY, 0, '0, 1'b1);
				end else begin
					for (k = 0; k < n_entries; k++)
						push_word(STAT_OK, k + 1, table_vals[k], k + 1 == n_entries);
				end
			end
			default: ;
		endcase
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2: return VAL_NEG1;
			3, 4: return $urandom_range(3);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_word(input table_cmd_t cmd);
		int n0;
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, cmd.val, cmd.pos};
		s_axis_tuser  <= cmd.op;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		n0 = expected_words.size();
		table_apply(cmd.op, cmd.pos, cmd.val);
		if (cmd.lit) begin
			while (expected_words.size() > n0)
				void'(expected_words.pop_back());
			push_word(cmd.lit_status, 0, '0, 1'b1);
			expected_words[$].count = cmd.lit_count;
		end
	endtask

	// result side: random backpressure, none during the steady stretch
	always @(posedge clk)
		m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);

	always @(posedge clk) begin : check_words
		out_word_t w;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_words.size() == 0) begin
				$display("%t unexpected word: status %0d position %0d value %h count %0d last %b",
					$time, m_axis_tuser, m_axis_tdata[6:0], m_axis_tdata[38:7],
					m_axis_tdata[45:39], m_axis_tlast);
				failed = 1'b1;
			end else begin
				w = expected_words.pop_front();
				if (w.status !== m_axis_tuser) begin
					$display("%t status: expected %0d got %0d", $time, w.status, m_axis_tuser);
					failed = 1'b1;
				end
				if (w.position !== m_axis_tdata[6:0]) begin
					$display("%t position: expected %0d got %0d", $time, w.position,
						m_axis_tdata[6:0]);
					failed = 1'b1;
				end
				if (w.value !== m_axis_tdata[38:7]) begin
					$display("%t value: expected %h got %h", $time, w.value, m_axis_tdata[38:7]);
					failed = 1'b1;
				end
				if (w.count !== m_axis_tdata[45:39]) begin
					$display("%t count: expected %0d got %0d", $time, w.count,
						m_axis_tdata[45:39]);
					failed = 1'b1;
				end
				if (w.last !== m_axis_tlast) begin
					$display("%t last: expected %b got %b", $time, w.last, m_axis_tlast);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin : stimulus
		table_cmd_t cmd;
		int done_items;
		int r;
		bit growing;
		bit noise;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_word(directed_cmds[i]);

		// random walk: fill toward a full table, then drain toward empty
		growing    = 1'b1;
		done_items = 0;
		while (done_items < N_RANDOM) begin
			steady = done_items >= 120 && done_items < 190;
			r      = $urandom_range(99);
			noise  = 1'b0;
			cmd.lit = 1'b0;
			cmd.lit_status = STAT_OK;
			cmd.lit_count  = '0;
			cmd.val = pick_value();
			if (r < 66)
				cmd.op = growing ? OP_INSERT : OP_DELETE;
			else if (r < 74)
				cmd.op = growing ? OP_DELETE : OP_INSERT;
			else if (r < 86)
				cmd.op = OP_SEARCH;
			else if (r < 90)
				cmd.op = OP_DISPLAY;
			else if (r < 93)
				cmd.op = OP_SORT;
			else if (r < 97) begin
				cmd.op = $urandom_range(1) ? OP_INSERT : OP_DELETE;
				noise  = 1'b1;
			end else
				cmd.op = OP_W'($urandom_range(OP_RSV_LAST, OP_RSV_FIRST));

			if (noise || n_entries == 0 && cmd.op == OP_DELETE)
				cmd.pos = POS_W'($urandom_range(127));
			else if (cmd.op == OP_INSERT)
				cmd.pos = POS_W'($urandom_range(n_entries + 1, 1));
			else if (cmd.op == OP_DELETE)
				cmd.pos = POS_W'($urandom_range(n_entries, 1));
			else
				cmd.pos = POS_W'($urandom_range(127));

			if (cmd.op == OP_SEARCH && n_entries > 0 && $urandom_range(1))
				cmd.val = table_vals[$urandom_range(n_entries - 1)];

			send_word(cmd);
			if (cmd.op <= OP_DISPLAY)
				done_items++;
			if (growing && n_entries == TABLE_DEPTH && $urandom_range(3) == 0)
				growing = 1'b0;
			else if (!growing && n_entries == 0 && $urandom_range(2) == 0)
				growing = 1'b1;
		end
		s_axis_tvalid <= 1'b0;
		steady = 1'b0;

		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failed)
			$display("[FAIL] regression broken");
		else
			$display("[ OK ] regression clean");
		$finish;
	end

	initial begin : watchdog
		#50_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
